// ===== hw/rtl/bsmw_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmw_pkg
// Shared constants, codes and interface structs of the bank-switched
// memory window unit.
// ----------------------------------------------------------------------------
package bsmw_pkg;

  localparam int SLOTS     = 8;
  localparam int MEM_BYTES = 131072;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int N_W    = $clog2(SLOTS + 1);
  localparam int ADDR_W = $clog2(MEM_BYTES);
  // bank (10 bits) shifted by up to 16, plus a 16-bit offset
  localparam int PA_W   = 27;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_SLOTS = 2'd2;

  localparam logic [4:0]  SIZE_RST  = 5'd13;
  localparam logic [10:0] COUNT_RST = 11'd8;
  localparam logic [3:0]  SLOTS_RST = 4'd2;

  typedef struct packed {
    logic [4:0]  size_log2;
    logic [10:0] bank_count;
    logic [3:0]  slots_in_use;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              step;
    logic              load_out;
    logic [SLOT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rw;
    logic is_read;
    logic hit;
    logic in_range;
    logic last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bsmw_regs.sv =====
// ----------------------------------------------------------------------------
// bsmw_regs
// APB-style configuration registers: bank size, bank count, slots in use.
// ----------------------------------------------------------------------------
module bsmw_regs import bsmw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [4:0]  size_r;
  logic [10:0] count_r;
  logic [3:0]  slots_r;
  logic        wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RST;
      count_r <= COUNT_RST;
      slots_r <= SLOTS_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SIZE:  size_r  <= pwdata[4:0];
        REG_COUNT: count_r <= pwdata[10:0];
        REG_SLOTS: slots_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE:  prdata = {27'd0, size_r};
      REG_COUNT: prdata = {21'd0, count_r};
      REG_SLOTS: prdata = {28'd0, slots_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg.size_log2    = size_r;
  assign cfg.bank_count   = count_r;
  assign cfg.slots_in_use = slots_r;

endmodule

// ===== hw/rtl/bsmw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsmw_ctrl
// Sequencer: takes one item, scans the slot table one slot per cycle,
// waits for the memory read and hands the result to the output register.
// ----------------------------------------------------------------------------
module bsmw_ctrl import bsmw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (stat.is_read && stat.hit && stat.in_range) begin
          state_nxt = ST_RDWAIT;
        end else if (!stat.is_rw || stat.last || (stat.is_read && stat.hit)) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_RDWAIT: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.capture  = (state_r == ST_IDLE) && in_valid;
  assign cmd.step     = (state_r == ST_SCAN);
  assign cmd.load_out = load_out;
  assign cmd.idx      = idx_r;

endmodule

// ===== hw/rtl/bsmw_dp.sv =====
// ----------------------------------------------------------------------------
// bsmw_dp
// Datapath: item registers, slot table, window match and physical address,
// banked byte memory and the result register.
// ----------------------------------------------------------------------------
module bsmw_dp import bsmw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [9:0]  in_new_bank,
  input  logic signed [3:0] in_slot_override,
  input  logic [16:0] in_phys_addr,
  output dp_stat_t    stat,
  output logic [7:0]  out_rdata,
  output logic [1:0]  out_status
);

  // item registers
  logic [1:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [9:0]  nbank_r;
  logic [3:0]  ovr_r;
  logic [16:0] paddr_r;

  // slot table
  logic        valid_r [SLOTS];
  logic [15:0] start_r [SLOTS];
  logic [9:0]  bank_r  [SLOTS];

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q_r;

  // per-item flags
  logic        rd_ok_r, any_r, skip_r;
  logic [1:0]  res_status_r;
  logic [7:0]  out_rdata_r;
  logic [1:0]  out_status_r;

  logic [4:0]        lg;
  logic [N_W-1:0]    n_eff;
  logic [N_W-1:0]    idx_ext;
  logic              in_n;
  logic              s_valid;
  logic [15:0]       s_start;
  logic [9:0]        s_bank;
  logic [15:0]       off;
  logic [16:0]       win;
  logic              hit;
  logic [PA_W-1:0]   pa;
  logic              in_range;
  logic              is_read, is_write, is_set, is_load;
  logic [15:0]       slot_sel;
  logic              set_bad;
  logic              load_ok;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;

  assign lg      = (cfg.size_log2 > 5'd16) ? 5'd16 : cfg.size_log2;
  assign n_eff   = (cfg.slots_in_use > SLOTS) ? N_W'(SLOTS) : N_W'(cfg.slots_in_use);
  assign idx_ext = N_W'(cmd.idx);
  assign in_n    = idx_ext < n_eff;

  assign s_valid = valid_r[cmd.idx];
  assign s_start = start_r[cmd.idx];
  assign s_bank  = bank_r[cmd.idx];

  assign off      = addr_r - s_start;
  assign win      = 17'd1 << lg;
  assign hit      = s_valid && in_n && (addr_r >= s_start) && ({1'b0, off} < win);
  assign pa       = (PA_W'(s_bank) << lg) + PA_W'(off);
  assign in_range = pa < PA_W'(MEM_BYTES);

  assign is_read  = (cmd_r == CMD_READ);
  assign is_write = (cmd_r == CMD_WRITE);
  assign is_set   = (cmd_r == CMD_SET);
  assign is_load  = (cmd_r == CMD_LOAD);

  // slot for set bank: override, else start >> size, else slot 0
  always_comb begin
    if (!ovr_r[3]) begin
      slot_sel = {13'd0, ovr_r[2:0]};
    end else if (cfg.slots_in_use > 4'd1) begin
      slot_sel = addr_r >> lg;
    end else begin
      slot_sel = 16'd0;
    end
  end

  assign set_bad = (slot_sel >= 16'(SLOTS)) || ({1'b0, nbank_r} >= cfg.bank_count);
  assign load_ok = {15'd0, paddr_r} < 32'(MEM_BYTES);

  assign mem_we    = cmd.step && ((is_write && hit && in_range) || (is_load && load_ok));
  assign mem_re    = cmd.step && is_read && hit && in_range;
  assign mem_waddr = is_load ? ADDR_W'(paddr_r) : pa[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wdata_r;
    end
    if (mem_re) begin
      mem_q_r <= mem[pa[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      wdata_r <= in_wdata;
      nbank_r <= in_new_bank;
      ovr_r   <= in_slot_override;
      paddr_r <= in_phys_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.step && is_set && !set_bad) begin
      valid_r[slot_sel[SLOT_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && is_set && !set_bad) begin
      start_r[slot_sel[SLOT_W-1:0]] <= addr_r;
      bank_r[slot_sel[SLOT_W-1:0]]  <= nbank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r      <= 1'b0;
      any_r        <= 1'b0;
      skip_r       <= 1'b0;
      res_status_r <= STAT_OK;
    end else if (cmd.capture) begin
      rd_ok_r      <= 1'b0;
      any_r        <= 1'b0;
      skip_r       <= 1'b0;
      res_status_r <= STAT_OK;
    end else if (cmd.step) begin
      if (mem_re) begin
        rd_ok_r <= 1'b1;
      end
      if (is_write && hit) begin
        any_r <= 1'b1;
        if (!in_range) begin
          skip_r <= 1'b1;
        end
      end
      if (is_set && set_bad) begin
        res_status_r <= STAT_BAD;
      end
      if (is_load && !load_ok) begin
        res_status_r <= STAT_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd_r)
        CMD_READ: begin
          out_rdata_r  <= rd_ok_r ? mem_q_r : 8'd0;
          out_status_r <= rd_ok_r ? STAT_OK : STAT_MISS;
        end
        CMD_WRITE: begin
          out_rdata_r  <= 8'd0;
          out_status_r <= (!any_r || skip_r) ? STAT_MISS : STAT_OK;
        end
        default: begin
          out_rdata_r  <= 8'd0;
          out_status_r <= res_status_r;
        end
      endcase
    end
  end

  assign stat.is_rw    = is_read || is_write;
  assign stat.is_read  = is_read;
  assign stat.hit      = hit;
  assign stat.in_range = in_range;
  assign stat.last     = (idx_ext + N_W'(1)) >= n_eff;

  assign out_rdata  = out_rdata_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/bank_switched_memory_window_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switched_memory_window_unit
// Slot table mapping CPU windows onto banks of a byte memory.
// Per item: set bank and load step from the scan state to the finish state; a
//   read scans slots from 0 to its first hit, then passes the read-wait state
//   unless that bank lies beyond memory; a read miss and a write scan every slot
//   in use (at least one); the finish state holds while the output is stalled.
// Items are taken one at a time, the next the cycle after its result is loaded.
// Reset clears the controller, all slot valid bits and the config registers
//   (13, 8, 2); memory contents are left as they are.
// ----------------------------------------------------------------------------
module bank_switched_memory_window_unit import bsmw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [9:0]  in_new_bank,
  input  logic signed [3:0] in_slot_override,
  input  logic [16:0] in_phys_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_rdata,
  output logic [1:0]  out_status
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsmw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsmw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .in_cmd           (in_cmd),
    .in_addr          (in_addr),
    .in_wdata         (in_wdata),
    .in_new_bank      (in_new_bank),
    .in_slot_override (in_slot_override),
    .in_phys_addr     (in_phys_addr),
    .stat             (stat),
    .out_rdata        (out_rdata),
    .out_status       (out_status)
  );

  // one item in flight: a transfer in closes the input side for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rdata != 8'd0) |-> out_status == STAT_OK)
    else $error("nonzero read data with a failing status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // an input transfer is never followed at once by a rising out_valid
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after input transfer");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the bank-switched memory window unit. Drives the input
// channel with directed and random accesses, with random gaps and output
// stalls, and programs the registers through the APB-style port between
// phases. A built-in model of the slot table and of physical memory predicts
// each result, and the results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bsmw_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int PRINT_MAX  = 40;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       addr;
    logic [7:0]        wdata;
    logic [9:0]        new_bank;
    logic signed [3:0] slot_override;
    logic [16:0]       phys_addr;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [1:0] status;
  } reply_t;

  localparam int ACC_W = $bits(access_t);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cmd = '0;
  logic [15:0]       in_addr = '0;
  logic [7:0]        in_wdata = '0;
  logic [9:0]        in_new_bank = '0;
  logic signed [3:0] in_slot_override = '0;
  logic [16:0]       in_phys_addr = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_rdata;
  logic [1:0]        out_status;

  // model of the block: registers, slot table and physical memory
  logic [4:0]  cur_size = SIZE_RST;
  logic [10:0] cur_count = COUNT_RST;
  logic [3:0]  cur_slots = SLOTS_RST;
  bit          win_valid [SLOTS];
  logic [15:0] win_start [SLOTS];
  logic [9:0]  win_bank [SLOTS];
  logic [7:0]  phys_mem [MEM_BYTES];
  bit          phys_known [MEM_BYTES];

  reply_t pending_q [$];
  int     err_count = 0;
  int     checked = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;
  bit     steady = 1'b0;

  bank_switched_memory_window_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_addr          (in_addr),
    .in_wdata         (in_wdata),
    .in_new_bank      (in_new_bank),
    .in_slot_override (in_slot_override),
    .in_phys_addr     (in_phys_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rdata        (out_rdata),
    .out_status       (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int size_eff();
    return (cur_size > 5'd16) ? 16 : int'(cur_size);
  endfunction

  function automatic int slots_eff();
    return (cur_slots > SLOTS) ? SLOTS : int'(cur_slots);
  endfunction

  function automatic bit window_hit(input int i, input logic [15:0] a, output longint pa);
    int lg;
    int off;
    lg = size_eff();
    pa = 0;
    if (!win_valid[i] || a < win_start[i]) return 1'b0;
    off = int'(a) - int'(win_start[i]);
    if (off >= (1 << lg)) return 1'b0;
    pa = (longint'(win_bank[i]) << lg) + longint'(off);
    return 1'b1;
  endfunction

  // physical address behind the first searched slot that covers a
  function automatic bit read_target(input logic [15:0] a, output longint pa);
    pa = 0;
    for (int i = 0; i < slots_eff(); i++)
      if (window_hit(i, a, pa)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic reply_t apply_access(input access_t t);
    reply_t r;
    longint pa;
    int     slot;
    bit     any;
    bit     skipped;
    r.rdata = '0;
    r.status = STAT_OK;
    any = 1'b0;
    skipped = 1'b0;
    case (t.cmd)
      CMD_READ: begin
        if (read_target(t.addr, pa) && pa < MEM_BYTES) r.rdata = phys_mem[pa];
        else r.status = STAT_MISS;
      end
      CMD_WRITE: begin
        for (int i = 0; i < slots_eff(); i++) begin
          if (window_hit(i, t.addr, pa)) begin
            any = 1'b1;
            if (pa < MEM_BYTES) begin
              phys_mem[pa] = t.wdata;
              phys_known[pa] = 1'b1;
            end else begin
              skipped = 1'b1;
            end
          end
        end
        if (!any || skipped) r.status = STAT_MISS;
      end
      CMD_SET: begin
        if (!t.slot_override[3]) slot = int'(t.slot_override[2:0]);
        else if (cur_slots > 1) slot = int'(t.addr) >> size_eff();
        else slot = 0;
        if (slot >= SLOTS || t.new_bank >= cur_count) begin
          r.status = STAT_BAD;
        end else begin
          win_valid[slot] = 1'b1;
          win_start[slot] = t.addr;
          win_bank[slot] = t.new_bank;
        end
      end
      CMD_LOAD: begin
        if (t.phys_addr < MEM_BYTES) begin
          phys_mem[t.phys_addr] = t.wdata;
          phys_known[t.phys_addr] = 1'b1;
        end else begin
          r.status = STAT_MISS;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (steady || r < 55) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(13, 40));
  endfunction

  function automatic access_t make_item(input logic [1:0] c, input logic [15:0] a,
                                        input logic [7:0] d, input logic [9:0] b,
                                        input logic signed [3:0] o, input logic [16:0] p);
    access_t t;
    t.cmd = c;
    t.addr = a;
    t.wdata = d;
    t.new_bank = b;
    t.slot_override = o;
    t.phys_addr = p;
    return t;
  endfunction

  // mostly accesses aimed at mapped windows, the rest raw noise
  function automatic access_t random_access();
    access_t t;
    int      r;
    int      lg;
    int      s;
    longint  pa;
    t = access_t'(ACC_W'({$urandom, $urandom}));
    lg = size_eff();
    r = int'($urandom_range(0, 99));
    if (r < 20) begin
      t.cmd = CMD_SET;
      if ($urandom_range(0, 1)) t.addr = 16'($urandom_range(0, SLOTS - 1) << lg);
      if (cur_count != 0 && $urandom_range(0, 4) != 0)
        t.new_bank = 10'($urandom_range(0, (cur_count > 1024) ? 1023 : cur_count - 1));
    end else begin
      t.cmd = (r < 55) ? CMD_READ : (r < 85) ? CMD_WRITE : CMD_LOAD;
      s = int'($urandom_range(0, SLOTS - 1));
      if (win_valid[s] && $urandom_range(0, 3) != 0) begin
        t.addr = 16'(win_start[s] + ($urandom & ((1 << lg) - 1)));
        pa = (longint'(win_bank[s]) << lg) + longint'($urandom & ((1 << lg) - 1));
        if (pa < MEM_BYTES && $urandom_range(0, 1)) t.phys_addr = pa[16:0];
      end
    end
    return t;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_MAX)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, checked, field, got, want);
  endtask

  // one transfer on the input channel; valid stays high after it
  task automatic push_item(input access_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= t.cmd;
    in_addr <= t.addr;
    in_wdata <= t.wdata;
    in_new_bank <= t.new_bank;
    in_slot_override <= t.slot_override;
    in_phys_addr <= t.phys_addr;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(apply_access(t));
  endtask

  // never read a byte that was never written: load it first
  task automatic send_access(input access_t t);
    longint pa;
    if (t.cmd == CMD_READ && read_target(t.addr, pa) && pa < MEM_BYTES && !phys_known[pa])
      push_item(make_item(CMD_LOAD, 16'($urandom), 8'($urandom), 10'($urandom),
                          4'($urandom), pa[16:0]));
    push_item(t);
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIZE:  cur_size = val[4:0];
      REG_COUNT: cur_count = val[10:0];
      REG_SLOTS: cur_slots = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] sz, input logic [10:0] cnt, input logic [3:0] sl);
    wait_all_replies();
    cfg_write(REG_SIZE, 32'(sz));
    cfg_write(REG_COUNT, 32'(cnt));
    cfg_write(REG_SLOTS, 32'(sl));
  endtask

  task automatic run_phase(input logic [4:0] sz, input logic [10:0] cnt, input logic [3:0] sl,
                           input int n, input bit hold_mid);
    set_config(sz, cnt, sl);
    for (int k = 0; k < n; k++) begin
      if (hold_mid && k == n / 2) wait_all_replies();
      send_access(random_access());
    end
  endtask

  task automatic test_after_reset();
    send_access(make_item(CMD_READ, 16'h0000, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_WRITE, 16'hFFFF, 8'hFF, 10'h3FF, -4'sd1, 17'h1FFFF));
    send_access(make_item(CMD_LOAD, 16'h0000, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_LOAD, 16'hFFFF, 8'hFF, 10'h3FF, -4'sd1, 17'h1FFFF));
  endtask

  task automatic test_set_bank_rules();
    send_access(make_item(CMD_SET, 16'h2000, 8'h00, 10'd7, -4'sd1, 17'd0));
    send_access(make_item(CMD_SET, 16'hE000, 8'h00, 10'd0, -4'sd1, 17'd0));
    send_access(make_item(CMD_SET, 16'h0000, 8'h00, 10'd8, 4'sd0, 17'd0));
    send_access(make_item(CMD_SET, 16'h0000, 8'h00, 10'h3FF, -4'sd8, 17'd0));
    send_access(make_item(CMD_SET, 16'h0000, 8'h00, 10'd3, 4'sd0, 17'd0));
  endtask

  task automatic test_window_access();
    send_access(make_item(CMD_WRITE, 16'h2000, 8'hA5, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_READ, 16'h2000, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_READ, 16'h1FFF, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_READ, 16'h4000, 8'h00, 10'd0, 4'sd0, 17'd0));
  endtask

  // 64 KiB banks: any bank above 1 lies outside physical memory
  task automatic test_beyond_memory();
    set_config(5'd16, 11'd1024, 4'd8);
    send_access(make_item(CMD_SET, 16'h1000, 8'h00, 10'd2, 4'sd3, 17'd0));
    send_access(make_item(CMD_READ, 16'h1000, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_SET, 16'h1000, 8'h00, 10'd1, 4'sd0, 17'd0));
    send_access(make_item(CMD_WRITE, 16'h2000, 8'h3C, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_READ, 16'h2000, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_SET, 16'hFFFF, 8'h00, 10'd1023, -4'sd1, 17'd0));
  endtask

  task automatic test_config_extremes();
    set_config(5'd31, 11'd0, 4'd15);
    send_access(make_item(CMD_SET, 16'h0000, 8'h00, 10'd0, 4'sd5, 17'd0));
    set_config(5'd0, 11'd2047, 4'd1);
    send_access(make_item(CMD_SET, 16'h0009, 8'h00, 10'd4, -4'sd1, 17'd0));
    send_access(make_item(CMD_READ, 16'h0009, 8'h00, 10'd0, 4'sd0, 17'd0));
    send_access(make_item(CMD_READ, 16'h000A, 8'h00, 10'd0, 4'sd0, 17'd0));
    set_config(5'd0, 11'd2047, 4'd3);
    send_access(make_item(CMD_SET, 16'h0008, 8'h00, 10'd1, -4'sd1, 17'd0));
    set_config(5'd0, 11'd2047, 4'd0);
    send_access(make_item(CMD_WRITE, 16'h0009, 8'h5A, 10'd0, 4'sd0, 17'd0));
  endtask

  task automatic test_random_traffic();
    run_phase(5'd13, 11'd8, 4'd2, 130, 1'b0);
    run_phase(5'd16, 11'd1024, 4'd8, 130, 1'b1);
    run_phase(5'd0, 11'd1, 4'd1, 100, 1'b0);
    run_phase(5'd10, 11'd64, 4'd8, 150, 1'b0);
    run_phase(5'd31, 11'd2047, 4'd15, 130, 1'b0);
    run_phase(5'd12, 11'd0, 4'd4, 60, 1'b0);
    repeat (3)
      run_phase(5'($urandom_range(0, 16)), 11'($urandom_range(1, 1024)),
                4'($urandom_range(1, 8)), 130, 1'b0);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_phase(5'd8, 11'd256, 4'd8, 150, 1'b0);
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_set_bank_rules();
    test_window_access();
    test_beyond_memory();
    test_config_extremes();
    test_random_traffic();
    test_back_to_back();
    wait_all_replies();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output stalls: mostly short, a few long, none while steady
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer, status", int'(out_status), -1);
      end else begin
        want = pending_q.pop_front();
        if (out_rdata !== want.rdata)
          report_mismatch("rdata", int'(out_rdata), int'(want.rdata));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
      end
      checked++;
    end
  end

  // end the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== bank_switched_memory_window_unit.f =====
hw/rtl/bsmw_pkg.sv
hw/rtl/bsmw_regs.sv
hw/rtl/bsmw_ctrl.sv
hw/rtl/bsmw_dp.sv
hw/rtl/bank_switched_memory_window_unit.sv
bench/tb_top.sv
